// File: hdl/bpd_pkg.sv
// Package for the button press duration classifier.
// Holds the transaction types, phase codes, register indexes and counter helpers.
// No dependencies.
`default_nettype none

package bpd_pkg;

  // Counter width of the press timer.
  localparam int CountWidth = 8;
  localparam int RegWidth   = 8;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [RegWidth-1:0]   reg_val_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_MIDDLE   = 2'd1;
  localparam logic [1:0] CFG_LONG     = 2'd2;

  // Phase codes as reported in the result transaction.
  localparam logic [2:0] PH_WAIT_RELEASE = 3'd0;
  localparam logic [2:0] PH_IDLE         = 3'd1;
  localparam logic [2:0] PH_DEBOUNCE     = 3'd2;
  localparam logic [2:0] PH_SHORT_WIN    = 3'd3;
  localparam logic [2:0] PH_LONG_WIN     = 3'd4;

  // Flag bit positions.
  localparam int FlagShort  = 0;
  localparam int FlagMiddle = 1;
  localparam int FlagLong   = 2;

  typedef struct packed {
    logic       button_level;
    logic [2:0] clear_mask;
  } in_item_t;

  typedef struct packed {
    logic       short_press;
    logic       middle_press;
    logic       long_press;
    logic [2:0] phase;
  } out_item_t;

  // Window lengths handed to the classifier core.
  typedef struct packed {
    reg_val_t debounce_ticks;
    reg_val_t middle_ticks;
    reg_val_t long_ticks;
  } cfg_t;

  // Internal phase state, one-hot.
  typedef enum logic [4:0] {
    S_WAIT_RELEASE = 5'b00001,
    S_IDLE         = 5'b00010,
    S_DEBOUNCE     = 5'b00100,
    S_SHORT_WIN    = 5'b01000,
    S_LONG_WIN     = 5'b10000
  } phase_t;

  localparam logic [31:0] CountMax = 32'((64'd1 << CountWidth) - 64'd1);

  // Load a register value into the counter, saturating if the counter is narrower.
  function automatic count_t load_count(input reg_val_t v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > CountMax) begin
      return count_t'(CountMax);
    end
    return count_t'(wide);
  endfunction

endpackage

`default_nettype wire

// File: hdl/bpd_core.sv
// Classifier core: phase machine, press countdown and sticky press flags.
// Depends on bpd_pkg.
`default_nettype none

module bpd_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire bpd_pkg::in_item_t item,
  input  wire bpd_pkg::cfg_t     cfg,
  output bpd_pkg::out_item_t     result
);

  bpd_pkg::phase_t phase_r, phase_nxt;
  bpd_pkg::count_t count_r, count_nxt;
  logic [2:0]      flags_r, flags_nxt;

  bpd_pkg::count_t count_dec;
  logic            released;

  assign released  = item.button_level;
  assign count_dec = (count_r != '0) ? count_r - 1'b1 : count_r;

  // Next state for one tick: clear mask first, then the phase update.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    flags_nxt = flags_r & ~item.clear_mask;
    case (phase_r)
      bpd_pkg::S_WAIT_RELEASE: begin
        if (released) begin
          phase_nxt = bpd_pkg::S_IDLE;
          count_nxt = '0;
        end
      end
      bpd_pkg::S_IDLE: begin
        if (!released) begin
          phase_nxt = bpd_pkg::S_DEBOUNCE;
          count_nxt = bpd_pkg::load_count(cfg.debounce_ticks);
        end
      end
      bpd_pkg::S_DEBOUNCE: begin
        count_nxt = count_dec;
        if (released) begin
          phase_nxt = bpd_pkg::S_WAIT_RELEASE;
          count_nxt = '0;
        end else if (count_dec == '0) begin
          phase_nxt = bpd_pkg::S_SHORT_WIN;
          count_nxt = bpd_pkg::load_count(cfg.middle_ticks);
        end
      end
      bpd_pkg::S_SHORT_WIN: begin
        count_nxt = count_dec;
        if (released) begin
          phase_nxt = bpd_pkg::S_WAIT_RELEASE;
          count_nxt = '0;
          flags_nxt = 3'b001 << bpd_pkg::FlagShort;
        end else if (count_dec == '0) begin
          phase_nxt = bpd_pkg::S_LONG_WIN;
          count_nxt = bpd_pkg::load_count(cfg.long_ticks);
        end
      end
      bpd_pkg::S_LONG_WIN: begin
        count_nxt = count_dec;
        if (released) begin
          phase_nxt = bpd_pkg::S_WAIT_RELEASE;
          count_nxt = '0;
          flags_nxt = 3'b001 << bpd_pkg::FlagMiddle;
        end else if (count_dec == '0) begin
          phase_nxt = bpd_pkg::S_WAIT_RELEASE;
          flags_nxt = 3'b001 << bpd_pkg::FlagLong;
        end
      end
      default: begin
        phase_nxt = bpd_pkg::S_WAIT_RELEASE;
        count_nxt = '0;
      end
    endcase
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bpd_pkg::S_WAIT_RELEASE;
      count_r <= '0;
      flags_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Result of this tick, taken from the next state.
  always_comb begin
    result.short_press  = flags_nxt[bpd_pkg::FlagShort];
    result.middle_press = flags_nxt[bpd_pkg::FlagMiddle];
    result.long_press   = flags_nxt[bpd_pkg::FlagLong];
    case (phase_nxt)
      bpd_pkg::S_WAIT_RELEASE: result.phase = bpd_pkg::PH_WAIT_RELEASE;
      bpd_pkg::S_IDLE:         result.phase = bpd_pkg::PH_IDLE;
      bpd_pkg::S_DEBOUNCE:     result.phase = bpd_pkg::PH_DEBOUNCE;
      bpd_pkg::S_SHORT_WIN:    result.phase = bpd_pkg::PH_SHORT_WIN;
      bpd_pkg::S_LONG_WIN:     result.phase = bpd_pkg::PH_LONG_WIN;
      default:                 result.phase = bpd_pkg::PH_WAIT_RELEASE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/button_press_duration_classifier.sv
// Channel   Direction  Handshake        Payload
// in_       input      in_valid/stall   bpd_pkg::in_item_t  (one timer tick)
// out_      output     out_valid/stall  bpd_pkg::out_item_t (flags and phase)
// cfg_      input      cfg_valid/ready  2-bit index, 8-bit data
//
// One tick transaction is accepted per cycle; its result appears in the output
// register on the next cycle. The input is stalled only while the output register
// holds a result that the sink is stalling. Configuration writes are always ready.
// Synchronous active-low reset returns the phase to wait-release, clears the
// flags and counter, and loads the register defaults 5, 50 and 100.
//
// Top level: configuration registers, output register and the classifier core.
// Depends on bpd_pkg and bpd_core.
`default_nettype none

module button_press_duration_classifier (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bpd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bpd_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire bpd_pkg::reg_val_t  cfg_data
);

  bpd_pkg::cfg_t      cfg_r;
  bpd_pkg::out_item_t core_result;
  bpd_pkg::out_item_t out_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic               in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= 8'd5;
      cfg_r.middle_ticks   <= 8'd50;
      cfg_r.long_ticks     <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpd_pkg::CFG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_data;
        bpd_pkg::CFG_MIDDLE:   cfg_r.middle_ticks   <= cfg_data;
        bpd_pkg::CFG_LONG:     cfg_r.long_ticks     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bpd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_accept),
    .item    (in_data),
    .cfg     (cfg_r),
    .result  (core_result)
  );

  // Output register: loads on every accepted tick, empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // An accepted tick always leaves a result in the output register.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted tick produced no result");

  // The input is held off only while a result is waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // The press flags are mutually exclusive.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.short_press, out_data.middle_press,
                            out_data.long_press}))
    else $error("more than one press flag set");
`endif

endmodule

`default_nettype wire

// File: dv/button_press_duration_classifier_tb.sv
// Self-checking testbench for the button press duration classifier.
// Predicts flags and phase for every accepted tick transaction and checks each result.
// Depends on bpd_pkg and button_press_duration_classifier.

module button_press_duration_classifier_tb;
  import bpd_pkg::*;

  localparam logic [1:0] CfgUnused = 2'd3;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_e;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  reg_val_t   cfg_data;

  // Predicted state and window registers of the classifier.
  logic [2:0] phase_m;
  count_t     count_m;
  logic [2:0] flags_m;
  reg_val_t   debounce_m;
  reg_val_t   middle_m;
  reg_val_t   long_m;

  out_item_t   pending_results[$];
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned presses_seen[3];
  int unsigned errors;

  // Sender burst control and receiver stall control.
  bit          gaps_on;
  int unsigned burst_left;
  stall_mode_e stall_mode;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned pattern_pos;

  button_press_duration_classifier i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Load a register value into the press timer, saturating at the largest count.
  function automatic count_t clip_count(input reg_val_t v);
    if (32'(v) > ((32'd1 << CountWidth) - 32'd1)) begin
      return '1;
    end
    return count_t'(v);
  endfunction

  // Advance the predicted classifier by one tick and return the expected result.
  function automatic out_item_t classify_tick(input in_item_t t);
    out_item_t r;
    logic      released;
    released = t.button_level;
    // The clear mask acts before the tick update, so a flag set now survives.
    flags_m = flags_m & ~t.clear_mask;
    case (phase_m)
      PH_WAIT_RELEASE: begin
        if (released) begin
          phase_m = PH_IDLE;
          count_m = '0;
        end
      end
      PH_IDLE: begin
        if (!released) begin
          count_m = clip_count(debounce_m);
          phase_m = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE, PH_SHORT_WIN, PH_LONG_WIN: begin
        if (count_m != '0) begin
          count_m = count_m - 1'b1;
        end
        if (released) begin
          // A release during debounce drops the press without touching the flags.
          if (phase_m == PH_SHORT_WIN) begin
            flags_m = '0;
            flags_m[FlagShort] = 1'b1;
            presses_seen[FlagShort]++;
          end else if (phase_m == PH_LONG_WIN) begin
            flags_m = '0;
            flags_m[FlagMiddle] = 1'b1;
            presses_seen[FlagMiddle]++;
          end
          count_m = '0;
          phase_m = PH_WAIT_RELEASE;
        end else if (count_m == '0) begin
          if (phase_m == PH_DEBOUNCE) begin
            count_m = clip_count(middle_m);
            phase_m = PH_SHORT_WIN;
          end else if (phase_m == PH_SHORT_WIN) begin
            count_m = clip_count(long_m);
            phase_m = PH_LONG_WIN;
          end else begin
            // Long press is flagged while the button is still held.
            flags_m = '0;
            flags_m[FlagLong] = 1'b1;
            presses_seen[FlagLong]++;
            phase_m = PH_WAIT_RELEASE;
          end
        end
      end
      default: begin
        phase_m = PH_WAIT_RELEASE;
        count_m = '0;
      end
    endcase
    r.short_press  = flags_m[FlagShort];
    r.middle_press = flags_m[FlagMiddle];
    r.long_press   = flags_m[FlagLong];
    r.phase        = phase_m;
    return r;
  endfunction

  // Mostly no clearing, sometimes a random clear mask.
  function automatic logic [2:0] pick_mask();
    if ($urandom_range(0, 3) == 0) begin
      return 3'($urandom_range(0, 7));
    end
    return 3'd0;
  endfunction

  // Offer one tick transaction, with random gaps between bursts, and record its prediction.
  task automatic send_tick(input logic level, input logic [2:0] mask);
    in_item_t    item;
    int unsigned gap;
    item.button_level = level;
    item.clear_mask   = mask;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(classify_tick(item));
    ticks_sent++;
  endtask

  // Stop offering ticks and wait until every predicted result has been checked.
  task automatic wait_drained();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One configuration write transaction.
  task automatic write_reg(input logic [1:0] idx, input reg_val_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEBOUNCE: debounce_m = val;
      CFG_MIDDLE:   middle_m   = val;
      CFG_LONG:     long_m     = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_windows(input reg_val_t deb, input reg_val_t mid, input reg_val_t lng);
    wait_drained();
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_MIDDLE, mid);
    write_reg(CFG_LONG, lng);
  endtask

  // Release, hold the button for a number of ticks, then release again.
  task automatic hold_button(input int unsigned ticks, input bit noisy);
    repeat ($urandom_range(1, 2)) send_tick(1'b1, noisy ? pick_mask() : 3'd0);
    repeat (ticks) send_tick(1'b0, noisy ? pick_mask() : 3'd0);
    send_tick(1'b1, noisy ? pick_mask() : 3'd0);
  endtask

  // Walk through every phase and outcome by hand, first with the reset windows.
  task automatic test_directed();
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    send_tick(1'b0, 3'd0);            // held at start: stays waiting for release
    send_tick(1'b1, 3'd7);            // release, clear all with nothing set
    send_tick(1'b1, 3'd0);
    send_tick(1'b0, 3'd0);            // press starts debounce
    send_tick(1'b1, 3'd0);            // bounce: press rejected
    send_tick(1'b1, 3'd0);
    repeat (6) send_tick(1'b0, 3'd0); // debounce runs out into the short window
    send_tick(1'b1, 3'd1);            // short press set while short is cleared
    send_tick(1'b1, 3'd1);            // clear the short flag
    set_windows(8'd1, 8'd1, 8'd1);
    send_tick(1'b1, 3'd0);
    repeat (3) send_tick(1'b0, 3'd0);
    send_tick(1'b1, 3'd2);            // middle press set while middle is cleared
    send_tick(1'b1, 3'd0);
    repeat (4) send_tick(1'b0, 3'd0); // long flag set while still held
    send_tick(1'b0, 3'd0);
    send_tick(1'b1, 3'd4);            // release and clear the long flag
  endtask

  // Zero-length windows end on the next tick and the countdown holds at zero.
  task automatic test_zero_windows();
    set_windows(8'd0, 8'd0, 8'd0);
    stall_mode = STALL_RANDOM;
    gaps_on    = 1'b1;
    for (int unsigned h = 0; h <= 5; h++) begin
      hold_button(h, 1'b1);
    end
  endtask

  // Largest windows: one press that outlasts all three.
  task automatic test_max_windows();
    set_windows(8'd255, 8'd255, 8'd255);
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    hold_button(780, 1'b0);
  endtask

  // A write to the unused index must not disturb the windows.
  task automatic test_unused_index();
    set_windows(8'd2, 8'd3, 8'd3);
    write_reg(CfgUnused, 8'hA5);
    stall_mode = STALL_PATTERN;
    for (int unsigned h = 1; h <= 10; h++) begin
      hold_button(h, 1'b0);
    end
  endtask

  // Random presses, biased toward window edges, with some noise in between.
  task automatic test_random_presses();
    reg_val_t    deb;
    reg_val_t    mid;
    reg_val_t    lng;
    int unsigned seg_start;
    int          edge_ticks;
    int          hold;
    for (int unsigned seg = 0; seg < 4; seg++) begin
      deb = reg_val_t'($urandom_range(0, (seg == 3) ? 20 : 4));
      mid = reg_val_t'($urandom_range(0, (seg == 3) ? 40 : 10));
      lng = reg_val_t'($urandom_range(0, (seg == 3) ? 40 : 10));
      set_windows(deb, mid, lng);
      stall_mode = stall_mode_e'(seg % 3);
      gaps_on    = (seg != 1);
      seg_start  = ticks_sent;
      while (ticks_sent - seg_start < 130) begin
        if ($urandom_range(0, 9) < 8) begin
          if ($urandom_range(0, 1) == 0) begin
            hold = $urandom_range(0, deb + mid + lng + 4);
          end else begin
            case ($urandom_range(0, 2))
              0:       edge_ticks = deb + 1;
              1:       edge_ticks = deb + mid + 2;
              default: edge_ticks = deb + mid + lng + 3;
            endcase
            hold = edge_ticks + $signed($urandom_range(0, 4)) - 2;
            if (hold < 0) begin
              hold = 0;
            end
          end
          hold_button(hold, 1'b1);
        end else begin
          repeat ($urandom_range(1, 6))
            send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    set_windows(8'd2, 8'd4, 8'd4);
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    hold_req   = 60;
    for (int unsigned h = 0; h < 8; h++) begin
      hold_button(h + 2, 1'b1);
    end
    stall_mode = STALL_RANDOM;
    gaps_on    = 1'b1;
    for (int unsigned h = 0; h < 8; h++) begin
      hold_button($urandom_range(0, 16), 1'b1);
    end
  endtask

  // Receiver stall pattern, with a long hold-off counted here when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      pattern_pos = (pattern_pos + 1) % 7;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (stall_mode)
          STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
          STALL_PATTERN: out_stall <= (pattern_pos < 3);
          default:       out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest prediction.
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no prediction pending: %p", out_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (out_data.short_press !== want.short_press) begin
            $error("short_press: expected %0b, got %0b", want.short_press,
                   out_data.short_press);
            errors++;
          end
          if (out_data.middle_press !== want.middle_press) begin
            $error("middle_press: expected %0b, got %0b", want.middle_press,
                   out_data.middle_press);
            errors++;
          end
          if (out_data.long_press !== want.long_press) begin
            $error("long_press: expected %0b, got %0b", want.long_press,
                   out_data.long_press);
            errors++;
          end
          if (out_data.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, out_data.phase);
            errors++;
          end
        end
      end
    end
  end

  // Run limit.
  initial begin
    #1000000;
    $display("[button_press_duration_classifier] ERROR");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    phase_m     = PH_WAIT_RELEASE;
    count_m     = '0;
    flags_m     = '0;
    debounce_m  = 8'd5;
    middle_m    = 8'd50;
    long_m      = 8'd100;
    gaps_on     = 1'b0;
    burst_left  = 0;
    stall_mode  = STALL_NONE;
    hold_req    = 0;
    hold_left   = 0;
    pattern_pos = 0;
    ticks_sent  = 0;
    errors      = 0;
    results_checked = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_zero_windows();
    test_max_windows();
    test_unused_index();
    test_random_presses();
    test_backpressure();

    wait_drained();
    repeat (5) @(posedge clk);
    $display("Sent %0d ticks and checked %0d results over reset, zero, maximum and random windows.",
             ticks_sent, results_checked);
    $display("Presses classified: %0d short, %0d middle, %0d long.",
             presses_seen[FlagShort], presses_seen[FlagMiddle], presses_seen[FlagLong]);
    if (errors == 0) begin
      $display("[button_press_duration_classifier] OK");
    end else begin
      $display("[button_press_duration_classifier] ERROR");
    end
    $finish;
  end

endmodule
